// ----- hw/rtl/jacobi_poisson_sweep_2d_assert.svh -----
// assertion macros for the jacobi sweep checker
// no dependencies; expects clk and arst_n in the scope of use
`ifndef JACOBI_POISSON_SWEEP_2D_ASSERT_SVH
`define JACOBI_POISSON_SWEEP_2D_ASSERT_SVH

// same-cycle implication, off while reset is low
`define JPS_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("jps check failed");

// next-cycle implication, off while reset is low
`define JPS_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("jps check failed");

`endif

// ----- hw/rtl/jps_pkg.sv -----
// shared types, constants and helpers for the jacobi sweep block
// no dependencies
package jps_pkg;

	localparam int MAX_GRID  = 64;
	localparam int FRAC_BITS = 24;
	localparam int VAL_W     = 32;
	localparam int ROWCOL_W  = 6;
	localparam int GRID_W    = 7;
	localparam int STEP_W    = FRAC_BITS + 1;
	localparam int IDX_W     = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;
	localparam int NSUM_W    = VAL_W + 2;
	localparam int MAX_JOBS  = 3;
	localparam int JCNT_W    = 2;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = (STEP_W > GRID_W) ? STEP_W : GRID_W;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_STEP_SQUARED = CFG_IDX_W'(1);

	localparam logic [GRID_W-1:0] GRID_RESET = GRID_W'(7);
	// 1/64 in the fraction format
	localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1) << (FRAC_BITS - 6);

	typedef struct packed {
		logic signed [VAL_W-1:0] old_value;
		logic signed [VAL_W-1:0] source_value;
	} item_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] new_value;
		logic [ROWCOL_W-1:0]     cell_row;
		logic [ROWCOL_W-1:0]     cell_col;
		logic                    last_of_run;
	} result_t;

	// one line cell: row above (value, source) and two rows above (value)
	typedef struct packed {
		logic signed [VAL_W-1:0] near_value;
		logic signed [VAL_W-1:0] near_source;
		logic signed [VAL_W-1:0] far_value;
	} lane_t;

	// one pending cell update
	typedef struct packed {
		logic signed [NSUM_W-1:0] nsum;
		logic signed [VAL_W-1:0]  source;
		logic [IDX_W-1:0]         row;
		logic [IDX_W-1:0]         col;
		logic                     last;
	} job_t;

	// last valid index for a grid size, zero acting as one, clamped to the line length
	function automatic logic [IDX_W-1:0] grid_last(input logic [GRID_W-1:0] g);
		logic [IDX_W-1:0] r;
		if (g == '0) begin
			r = '0;
		end else if (32'(g) > MAX_GRID) begin
			r = IDX_W'(MAX_GRID - 1);
		end else begin
			r = IDX_W'(g - GRID_W'(1));
		end
		return r;
	endfunction

endpackage

// ----- hw/rtl/jps_cell.sv -----
// one cell of the line delay chain
// depends on jps_pkg
module jps_cell (
	input  logic          clk,
	input  logic          shift,
	input  logic          tail,
	input  jps_pkg::lane_t feed,
	input  jps_pkg::lane_t nbr,
	output jps_pkg::lane_t q
);
	import jps_pkg::*;

	lane_t lane_q;

	// the tail cell takes the new entry, the others take their right neighbor
	always_ff @(posedge clk) begin
		if (shift) begin
			lane_q <= tail ? feed : nbr;
		end
	end

	assign q = lane_q;

endmodule

// ----- hw/rtl/jps_update.sv -----
// stencil arithmetic: multiply stage, then round, saturate and output register
// depends on jps_pkg
module jps_update (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         job_valid,
	output logic                         job_ready,
	input  jps_pkg::job_t                job,
	input  logic [jps_pkg::STEP_W-1:0]   step,
	output logic                         result_valid,
	input  logic                         result_stall,
	output jps_pkg::result_t             result
);
	import jps_pkg::*;

	localparam int PROD_W = STEP_W + 1 + VAL_W;
	localparam int SUM_W  = PROD_W + 2;
	localparam int QUOT_W = SUM_W - FRAC_BITS - 2;
	localparam logic signed [SUM_W-1:0] ROUND_C = SUM_W'(1) <<< (FRAC_BITS + 1);
	localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	logic                      valid_s1;
	logic signed [NSUM_W-1:0]  nsum_s1;
	logic signed [PROD_W-1:0]  prod_s1;
	logic [IDX_W-1:0]          row_s1;
	logic [IDX_W-1:0]          col_s1;
	logic                      last_s1;

	logic                      out_valid_q;
	result_t                   out_q;

	logic                      adv_out;
	logic                      en_s1;
	logic signed [PROD_W-1:0]  prod_c;
	logic signed [SUM_W-1:0]   total_c;
	logic signed [QUOT_W-1:0]  quot_c;
	logic [QUOT_W-VAL_W:0]     hi_c;
	logic                      ovf_c;
	logic signed [VAL_W-1:0]   sat_c;

	assign adv_out   = !out_valid_q || !result_stall;
	assign en_s1     = !valid_s1 || adv_out;
	assign job_ready = en_s1;

	// h^2 is unsigned, so it gets a zero sign bit
	assign prod_c = $signed({1'b0, step}) * $signed(job.source);

	// exact sum, one shift with round half up
	assign total_c = (SUM_W'(nsum_s1) <<< FRAC_BITS) + SUM_W'(prod_s1) + ROUND_C;
	assign quot_c  = QUOT_W'(total_c >>> (FRAC_BITS + 2));
	assign hi_c    = quot_c[QUOT_W-1:VAL_W-1];
	assign ovf_c   = !((&hi_c) || !(|hi_c));
	assign sat_c   = ovf_c ? (quot_c[QUOT_W-1] ? VAL_MIN : VAL_MAX) : quot_c[VAL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= job_valid;
			end
			if (adv_out) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && job_valid) begin
			nsum_s1 <= job.nsum;
			prod_s1 <= prod_c;
			row_s1  <= job.row;
			col_s1  <= job.col;
			last_s1 <= job.last;
		end
		if (adv_out && valid_s1) begin
			out_q.new_value   <= sat_c;
			out_q.cell_row    <= ROWCOL_W'(row_s1);
			out_q.cell_col    <= ROWCOL_W'(col_s1);
			out_q.last_of_run <= last_s1;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

// ----- hw/rtl/jacobi_poisson_sweep_2d.sv -----
// top level of the jacobi sweep block: one sweep of the 5-point poisson stencil
// depends on jps_pkg, jps_cell, jps_update
//
// cells enter in raster order on cell_valid/cell_stall/cell_data (old value and
// source, signed q8.24); a transfer happens when valid is high and stall low.
// results leave on result_valid/result_stall/result_data as inputs complete them, each
// with its row, column and a flag on the last result caused by an input cell.
// cfg_valid/cfg_ready/cfg_index/cfg_data write grid_size (index 0, restarts the
// frame at cell 0,0) and step_squared (index 1); cfg_ready is always high.
// a result passes the pending-update queue, the multiply stage and the output register
// after the input transfer that completes it; further results of the same input follow it.
// throughput: one cell per cycle while the output does not stall; in the last row each
// input after the first completes two cells, the final one three; the next input waits.
// old values of the two rows above and sources of the row above sit in a chain of
// grid_size cells that shifts once per input transfer.
// reset: frame position to cell 0,0, grid_size 7, step_squared 2^-6; the line
// chain is not cleared, its entries are only read after the frame writes them.
// when the receiver stalls, the output register and the multiply stage hold,
// the updates of one more input cell wait in a queue of up to 3, then cell_stall rises.
module jacobi_poisson_sweep_2d (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cell_valid,
	output logic                            cell_stall,
	input  jps_pkg::item_t                  cell_data,
	output logic                            result_valid,
	input  logic                            result_stall,
	output jps_pkg::result_t                result_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [jps_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [jps_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import jps_pkg::*;

	// cell one to the right of the head, when the chain has one
	localparam int RIGHT_IDX = (MAX_GRID > 1) ? 1 : 0;

	// configuration and frame position
	logic [IDX_W-1:0]        last_q;
	logic [STEP_W-1:0]       step_q;
	logic [IDX_W-1:0]        row_q;
	logic [IDX_W-1:0]        col_q;

	// short history of the stream
	logic signed [VAL_W-1:0] left_q;    // row above, previous column
	logic signed [VAL_W-1:0] prev1_v_q; // previous input value
	logic signed [VAL_W-1:0] prev1_f_q; // previous input source
	logic signed [VAL_W-1:0] prev2_v_q; // input value two transfers back

	// pending cell updates
	job_t                    jobs_q [MAX_JOBS];
	logic [JCNT_W-1:0]       jcnt_q;

	lane_t                   lanes [MAX_GRID];
	lane_t                   feed_c;
	logic [MAX_GRID-1:0]     tail_c;

	logic                    cfg_we;
	logic                    accept_in;
	logic                    issue;
	logic                    upd_ready;
	logic                    has_a, has_b, has_c;
	logic                    row_first, col_first, row_last, col_last;
	job_t                    job_a, job_b, job_c;
	logic [JCNT_W-1:0]       njobs_c;
	lane_t                   head;
	logic signed [VAL_W-1:0] right_v;

	function automatic logic signed [NSUM_W-1:0] ext(
		input logic signed [VAL_W-1:0] v,
		input logic                    en
	);
		return en ? NSUM_W'(v) : '0;
	endfunction

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	// take a new cell once the queue empties in this cycle
	assign issue      = (jcnt_q != '0) && upd_ready;
	assign cell_stall = !((jcnt_q == '0) || ((jcnt_q == JCNT_W'(1)) && upd_ready));
	assign accept_in  = cell_valid && !cell_stall;

	// line chain: length follows the grid, entries leave at cell 0
	assign head    = lanes[0];
	assign right_v = lanes[RIGHT_IDX].near_value;

	always_comb begin
		feed_c.near_value  = cell_data.old_value;
		feed_c.near_source = cell_data.source_value;
		feed_c.far_value   = head.near_value;
	end

	for (genvar i = 0; i < MAX_GRID; i++) begin : g_chain
		assign tail_c[i] = (last_q == IDX_W'(i));
		if (i == MAX_GRID - 1) begin : g_end
			jps_cell u_cell (
				.clk   (clk),
				.shift (accept_in),
				.tail  (tail_c[i]),
				.feed  (feed_c),
				.nbr   (feed_c),
				.q     (lanes[i])
			);
		end else begin : g_mid
			jps_cell u_cell (
				.clk   (clk),
				.shift (accept_in),
				.tail  (tail_c[i]),
				.feed  (feed_c),
				.nbr   (lanes[i+1]),
				.q     (lanes[i])
			);
		end
	end

	// cells completed by the incoming one
	assign row_first = (row_q == '0);
	assign col_first = (col_q == '0);
	assign row_last  = (row_q == last_q);
	assign col_last  = (col_q == last_q);
	assign has_a     = !row_first;
	assign has_b     = row_last && !col_first;
	assign has_c     = row_last && col_last;
	assign njobs_c   = JCNT_W'(has_a) + JCNT_W'(has_b) + JCNT_W'(has_c);

	always_comb begin
		// the cell above the incoming one
		job_a.nsum   = ext(head.far_value, row_q > IDX_W'(1))
			+ ext(left_q, !col_first)
			+ ext(right_v, !col_last)
			+ ext(cell_data.old_value, 1'b1);
		job_a.source = head.near_source;
		job_a.row    = row_q - IDX_W'(1);
		job_a.col    = col_q;
		job_a.last   = !has_b && !has_c;

		// bottom row: the cell to the left of the incoming one
		job_b.nsum   = ext(left_q, 1'b1)
			+ ext(prev2_v_q, col_q > IDX_W'(1))
			+ ext(cell_data.old_value, 1'b1);
		job_b.source = prev1_f_q;
		job_b.row    = row_q;
		job_b.col    = col_q - IDX_W'(1);
		job_b.last   = !has_c;

		// bottom right corner: the incoming cell itself
		job_c.nsum   = ext(head.near_value, !row_first)
			+ ext(prev1_v_q, !col_first);
		job_c.source = cell_data.source_value;
		job_c.row    = row_q;
		job_c.col    = col_q;
		job_c.last   = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= grid_last(GRID_RESET);
			step_q <= STEP_RESET;
			row_q  <= '0;
			col_q  <= '0;
			jcnt_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_GRID_SIZE: begin
						last_q <= grid_last(cfg_data[GRID_W-1:0]);
					end
					REG_STEP_SQUARED: begin
						step_q <= cfg_data[STEP_W-1:0];
					end
					default: begin
					end
				endcase
			end
			// a grid size write restarts the frame, otherwise a transfer steps it
			if (cfg_we && (cfg_index == REG_GRID_SIZE)) begin
				row_q <= '0;
				col_q <= '0;
			end else if (accept_in) begin
				if (col_last) begin
					col_q <= '0;
					row_q <= row_last ? '0 : row_q + IDX_W'(1);
				end else begin
					col_q <= col_q + IDX_W'(1);
				end
			end
			if (accept_in) begin
				jcnt_q <= njobs_c;
			end else if (issue) begin
				jcnt_q <= jcnt_q - JCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			left_q    <= head.near_value;
			prev1_v_q <= cell_data.old_value;
			prev1_f_q <= cell_data.source_value;
			prev2_v_q <= prev1_v_q;
			// only the single-cell grid yields the corner cell alone
			jobs_q[0] <= has_a ? job_a : job_c;
			jobs_q[1] <= job_b;
			jobs_q[2] <= job_c;
		end else if (issue) begin
			jobs_q[0] <= jobs_q[1];
			jobs_q[1] <= jobs_q[2];
		end
	end

	jps_update u_update (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (jcnt_q != '0),
		.job_ready    (upd_ready),
		.job          (jobs_q[0]),
		.step         (step_q),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result_data)
	);

endmodule

// ----- hw/rtl/jps_checker.sv -----
// port-level checks for the jacobi sweep block, bound to the top level
// depends on jps_pkg and jacobi_poisson_sweep_2d_assert.svh
`include "jacobi_poisson_sweep_2d_assert.svh"

module jps_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             result_valid,
	input logic             result_stall,
	input jps_pkg::result_t result_data,
	input logic             cfg_valid,
	input logic             cfg_ready
);
	import jps_pkg::*;

	logic                out_xfer;
	logic                pend_q;
	logic [ROWCOL_W-1:0] prev_row_q;

	assign out_xfer = result_valid && !result_stall;

	// track a run whose last result has not gone out yet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q     <= 1'b0;
			prev_row_q <= '0;
		end else if (out_xfer) begin
			pend_q     <= !result_data.last_of_run;
			prev_row_q <= result_data.cell_row;
		end
	end

	// a stalled result holds
	`JPS_ASSERT_NEXT(a_out_hold, result_valid && result_stall, result_valid && $stable(result_data))

	// within one run a result is followed by the bottom-row cell or the corner
	`JPS_ASSERT_IMPL(a_run_order, result_valid && pend_q, (result_data.cell_row == prev_row_q) || (result_data.cell_row == prev_row_q + ROWCOL_W'(1)))

	// register writes are never held off
	`JPS_ASSERT_IMPL(a_cfg_taken, cfg_valid, cfg_ready)

endmodule

bind jacobi_poisson_sweep_2d jps_checker u_jps_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result_data  (result_data),
	.cfg_valid    (cfg_valid),
	.cfg_ready    (cfg_ready)
);
